// ===== rtl/slt_pkg.sv =====
// shared types, character codes and helpers for the shell line tokenizer
// no dependencies
package slt_pkg;

	localparam int QDEPTH = 4;
	localparam int QPW    = 2;

	localparam logic [7:0] CH_PIPE  = 8'h7C;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_SQUOT = 8'h27;
	localparam logic [7:0] CH_DQUOT = 8'h22;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;

	typedef enum logic [2:0] {
		KIND_WORD    = 3'd0,
		KIND_PIPE    = 3'd1,
		KIND_IN      = 3'd2,
		KIND_OUT     = 3'd3,
		KIND_HEREDOC = 3'd4,
		KIND_APPEND  = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		Q_NONE   = 3'b001,
		Q_SINGLE = 3'b010,
		Q_DOUBLE = 3'b100
	} quote_t;

	typedef enum logic [2:0] {
		P_NONE = 3'b001,
		P_IN   = 3'b010,
		P_OUT  = 3'b100
	} pend_t;

	typedef struct packed {
		kind_t       kind;
		logic [11:0] start;
		logic [12:0] length;
	} token_t;

	typedef struct packed {
		token_t tok0;
		token_t tok1;
		logic   two;
		logic   line_end;
		logic   overflow;
	} step_rec_t;

	function automatic logic is_blank(input logic [7:0] b);
		return b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR ||
			b == CH_VT || b == CH_FF;
	endfunction

	function automatic quote_t quote_track(input logic [7:0] b, input quote_t qs);
		quote_t r;
		r = qs;
		if (b == CH_SQUOT && qs != Q_DOUBLE) begin
			r = (qs == Q_SINGLE) ? Q_NONE : Q_SINGLE;
		end else if (b == CH_DQUOT && qs != Q_SINGLE) begin
			r = (qs == Q_DOUBLE) ? Q_NONE : Q_DOUBLE;
		end
		return r;
	endfunction

endpackage

// ===== rtl/shell_line_tokenizer.sv =====
// shell line tokenizer: one byte per request in, one token per request out
// a token passes a four-entry queue, then the output register, before it is valid
// throughput: one byte per cycle while the queue is not full; one token per cycle out
// while m_tready is high; the queue absorbs bytes that yield two tokens
// reset: asynchronous, clears lexer state, queue and output valid
module shell_line_tokenizer
	import slt_pkg::*;
#(
	parameter int MAX_LINE = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // byte_value[7:0]
	input  logic        s_tlast,  // line_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // token_start[11:0], token_length[24:12], zero[31:25]
	output logic        m_tlast,  // line_last_token
	output logic [4:0]  m_tuser   // token_kind[2:0], run_last[3], line_overflow[4]
);

	logic      take;
	logic      push;
	step_rec_t rec;
	step_rec_t head;
	logic      not_empty;
	logic      full;
	logic      pop;

	assign s_tready = !full;
	assign take     = s_tvalid && s_tready;

	slt_front #(
		.MAX_LINE(MAX_LINE)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.byte_value(s_tdata),
		.line_end  (s_tlast),
		.push      (push),
		.rec       (rec)
	);

	slt_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_rec   (rec),
		.pop      (pop),
		.head     (head),
		.not_empty(not_empty),
		.full     (full)
	);

	slt_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.not_empty(not_empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

// ===== rtl/slt_front.sv =====
// front end: lexer state, byte classification and token generation per request
// depends on slt_pkg
module slt_front
	import slt_pkg::*;
#(
	parameter int MAX_LINE = 4096
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] byte_value,
	input  logic       line_end,
	output logic       push,
	output step_rec_t  rec
);

	localparam int PW = $clog2(MAX_LINE + 1);
	localparam int XW = (PW > 13) ? PW : 13;

	logic [PW-1:0] position_q;
	logic          word_open_q;
	quote_t        quote_q;
	logic [PW-1:0] word_start_q;
	pend_t         pend_q;
	logic [PW-1:0] pend_start_q;
	logic          overflow_q;

	logic [PW-1:0] pos;
	logic          ovf;
	logic          wo;
	quote_t        qs;
	logic [PW-1:0] ws;
	pend_t         pr;
	logic [PW-1:0] ps;
	logic [1:0]    n;
	token_t        tk [2];

	function automatic token_t mk_tok(input kind_t k, input logic [PW-1:0] s,
		input logic [XW-1:0] len);
		token_t t;
		logic [XW-1:0] sx;
		sx       = XW'(s);
		t.kind   = k;
		t.start  = sx[11:0];
		t.length = len[12:0];
		return t;
	endfunction

	always_comb begin
		logic          consumed;
		logic          sp;
		logic          op;
		logic [7:0]    held;
		logic [XW-1:0] len;
		pos      = (position_q >= PW'(MAX_LINE)) ? PW'(MAX_LINE - 1) : position_q;
		ovf      = overflow_q | (position_q >= PW'(MAX_LINE));
		wo       = word_open_q;
		qs       = quote_q;
		ws       = word_start_q;
		pr       = pend_q;
		ps       = pend_start_q;
		n        = 2'd0;
		tk[0]    = '0;
		tk[1]    = '0;
		consumed = 1'b0;
		sp       = is_blank(byte_value);
		op       = byte_value == CH_PIPE || byte_value == CH_LT || byte_value == CH_GT;
		held     = (pr == P_IN) ? CH_LT : CH_GT;
		len      = '0;

		if (pr != P_NONE) begin
			if (byte_value == held) begin
				tk[0] = mk_tok((pr == P_IN) ? KIND_HEREDOC : KIND_APPEND, ps, XW'(2));
				consumed = 1'b1;
			end else begin
				tk[0] = mk_tok((pr == P_IN) ? KIND_IN : KIND_OUT, ps, XW'(1));
			end
			n  = 2'd1;
			pr = P_NONE;
		end

		if (!consumed) begin
			if (wo && qs == Q_NONE && (sp || op)) begin
				len = XW'(pos) - XW'(ws);
				if (len == '0) begin
					len = XW'(1);
				end
				if (n != 2'd2) begin
					tk[n[0]] = mk_tok(KIND_WORD, ws, len);
					n = n + 2'd1;
				end
				wo = 1'b0;
			end
			if (wo) begin
				qs = quote_track(byte_value, qs);
			end else if (!sp) begin
				if (byte_value == CH_PIPE) begin
					if (n != 2'd2) begin
						tk[n[0]] = mk_tok(KIND_PIPE, pos, XW'(1));
						n = n + 2'd1;
					end
				end else if (byte_value == CH_LT || byte_value == CH_GT) begin
					pr = (byte_value == CH_LT) ? P_IN : P_OUT;
					ps = pos;
				end else begin
					wo = 1'b1;
					ws = pos;
					qs = quote_track(byte_value, Q_NONE);
				end
			end
		end

		if (line_end) begin
			if (wo) begin
				len = XW'(pos) + XW'(1) - XW'(ws);
				if (n != 2'd2) begin
					tk[n[0]] = mk_tok(KIND_WORD, ws, len);
					n = n + 2'd1;
				end
			end
			if (pr != P_NONE) begin
				if (n != 2'd2) begin
					tk[n[0]] = mk_tok((pr == P_IN) ? KIND_IN : KIND_OUT, ps, XW'(1));
					n = n + 2'd1;
				end
			end
		end
	end

	assign push         = take && n != 2'd0;
	assign rec.tok0     = tk[0];
	assign rec.tok1     = tk[1];
	assign rec.two      = n == 2'd2;
	assign rec.line_end = line_end;
	assign rec.overflow = ovf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q   <= '0;
			word_open_q  <= 1'b0;
			quote_q      <= Q_NONE;
			word_start_q <= '0;
			pend_q       <= P_NONE;
			pend_start_q <= '0;
			overflow_q   <= 1'b0;
		end else if (take) begin
			if (line_end) begin
				position_q   <= '0;
				word_open_q  <= 1'b0;
				quote_q      <= Q_NONE;
				word_start_q <= '0;
				pend_q       <= P_NONE;
				pend_start_q <= '0;
				overflow_q   <= 1'b0;
			end else begin
				if (position_q < PW'(MAX_LINE)) begin
					position_q <= position_q + PW'(1);
				end
				word_open_q  <= wo;
				quote_q      <= qs;
				word_start_q <= ws;
				pend_q       <= pr;
				pend_start_q <= ps;
				overflow_q   <= ovf;
			end
		end
	end

	a_pend_no_word: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != P_NONE |-> !word_open_q)
		else $error("redirect held while a word is open");

	a_line_reset: assert property (@(posedge clk) disable iff (!arst_n)
		take && line_end |=> position_q == '0 && pend_q == P_NONE && !word_open_q)
		else $error("line end did not clear lexer state");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		position_q <= PW'(MAX_LINE))
		else $error("position past saturation");

endmodule

// ===== rtl/slt_queue.sv =====
// short queue of per-request token records between front and back
// depends on slt_pkg
module slt_queue
	import slt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  step_rec_t wr_rec,
	input  logic      pop,
	output step_rec_t head,
	output logic      not_empty,
	output logic      full
);

	step_rec_t      mem_q [QDEPTH];
	logic [QPW-1:0] wr_ptr_q;
	logic [QPW-1:0] rd_ptr_q;
	logic [QPW:0]   count_q;

	assign head      = mem_q[rd_ptr_q];
	assign not_empty = count_q != '0;
	assign full      = count_q == (QPW + 1)'(QDEPTH);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + (QPW + 1)'(1);
				2'b01:   count_q <= count_q - (QPW + 1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QPW + 1)'(QDEPTH))
		else $error("queue count out of range");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");

	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("pop from empty queue");

endmodule

// ===== rtl/slt_back.sv =====
// back end: splits queued records into single tokens and drives the output register
// depends on slt_pkg
module slt_back
	import slt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  step_rec_t   head,
	input  logic        not_empty,
	output logic        pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,
	output logic        m_tlast,
	output logic [4:0]  m_tuser
);

	logic   out_valid_q;
	token_t out_tok_q;
	logic   out_run_last_q;
	logic   out_line_last_q;
	logic   out_ovf_q;
	logic   half_q;

	logic   load;
	logic   last_tok;
	token_t cur_tok;

	assign load     = !out_valid_q || m_tready;
	assign last_tok = half_q || !head.two;
	assign cur_tok  = half_q ? head.tok1 : head.tok0;
	assign pop      = load && not_empty && last_tok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			half_q      <= 1'b0;
		end else if (load) begin
			out_valid_q <= not_empty;
			if (not_empty) begin
				half_q <= !last_tok;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && not_empty) begin
			out_tok_q       <= cur_tok;
			out_run_last_q  <= last_tok;
			out_line_last_q <= last_tok && head.line_end;
			out_ovf_q       <= head.overflow;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_tok_q.length, out_tok_q.start};
	assign m_tlast  = out_line_last_q;
	assign m_tuser  = {out_ovf_q, out_run_last_q, out_tok_q.kind};

endmodule

// ===== sim/testbench.sv =====
// testbench for shell_line_tokenizer: streams command lines in and checks each token
// against a lexer model kept in this file, under random idling on both sides
// depends on rtl/slt_pkg.sv and rtl/shell_line_tokenizer.sv
module testbench;
	import slt_pkg::*;

	localparam int LINE_MAX       = 4096;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct {
		kind_t       kind;
		logic [11:0] start;
		logic [12:0] length;
		logic        line_last;
		logic        run_last;
		logic        overflow;
	} lexed_token_t;

	typedef enum {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_RHYTHM} ready_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;  // byte_value[7:0]
	logic        s_tlast = 1'b0;   // line_end
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;          // token_start[11:0], token_length[24:12], zero[31:25]
	logic        m_tlast;          // line_last_token
	logic [4:0]  m_tuser;          // token_kind[2:0], run_last[3], line_overflow[4]

	// lexer model state
	int     line_pos = 0;
	bit     in_word = 1'b0;
	quote_t quote = Q_NONE;
	int     word_begin = 0;
	pend_t  held = P_NONE;
	int     held_begin = 0;
	bit     line_overflowed = 1'b0;

	lexed_token_t tokens_due[$];
	lexed_token_t want;
	int mismatches = 0;
	int bytes_sent = 0;
	int burst_left = 0;
	int quiet_cycles = 0;

	int          holds_asked = 0;
	int          holds_begun = 0;
	int          hold_left = 0;
	int          mode_left = 0;
	ready_mode_t ready_mode = RDY_ALWAYS;
	logic [7:0]  phase = 8'h00;

	shell_line_tokenizer #(.MAX_LINE(LINE_MAX)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

	always #2 clk = ~clk;

	function automatic bit is_separator(input logic [7:0] b);
		return b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR ||
			b == CH_VT || b == CH_FF;
	endfunction

	function automatic quote_t next_quote(input logic [7:0] b, input quote_t q);
		if (b == CH_SQUOT && q != Q_DOUBLE) begin
			return (q == Q_SINGLE) ? Q_NONE : Q_SINGLE;
		end
		if (b == CH_DQUOT && q != Q_SINGLE) begin
			return (q == Q_DOUBLE) ? Q_NONE : Q_DOUBLE;
		end
		return q;
	endfunction

	function automatic lexed_token_t make_tok(input kind_t kind, input int start, input int len);
		lexed_token_t t;
		t.kind      = kind;
		t.start     = start[11:0];
		t.length    = len[12:0];
		t.line_last = 1'b0;
		t.run_last  = 1'b0;
		t.overflow  = 1'b0;
		return t;
	endfunction

	// runs one byte through the lexer model and queues the tokens it yields
	task automatic lex_byte(input logic [7:0] b, input logic last);
		lexed_token_t toks[$];
		int  pos;
		int  len;
		bit  taken;
		bit  blank;
		bit  oper;
		taken = 1'b0;
		pos = line_pos;
		if (pos >= LINE_MAX) begin
			pos = LINE_MAX - 1;
			line_overflowed = 1'b1;
		end
		if (held != P_NONE) begin
			if (b == ((held == P_IN) ? CH_LT : CH_GT)) begin
				toks.push_back(make_tok((held == P_IN) ? KIND_HEREDOC : KIND_APPEND,
					held_begin, 2));
				taken = 1'b1;
			end else begin
				toks.push_back(make_tok((held == P_IN) ? KIND_IN : KIND_OUT, held_begin, 1));
			end
			held = P_NONE;
		end
		if (!taken) begin
			blank = is_separator(b);
			oper = b == CH_PIPE || b == CH_LT || b == CH_GT;
			if (in_word && quote == Q_NONE && (blank || oper)) begin
				len = pos - word_begin;
				if (len == 0) begin
					len = 1;
				end
				toks.push_back(make_tok(KIND_WORD, word_begin, len));
				in_word = 1'b0;
			end
			if (in_word) begin
				quote = next_quote(b, quote);
			end else if (b == CH_PIPE) begin
				toks.push_back(make_tok(KIND_PIPE, pos, 1));
			end else if (b == CH_LT || b == CH_GT) begin
				held = (b == CH_LT) ? P_IN : P_OUT;
				held_begin = pos;
			end else if (!blank) begin
				in_word = 1'b1;
				word_begin = pos;
				quote = next_quote(b, Q_NONE);
			end
		end
		if (last) begin
			if (in_word) begin
				toks.push_back(make_tok(KIND_WORD, word_begin, pos + 1 - word_begin));
			end
			if (held != P_NONE) begin
				toks.push_back(make_tok((held == P_IN) ? KIND_IN : KIND_OUT, held_begin, 1));
			end
		end
		while (toks.size() > 2) begin
			void'(toks.pop_back());
		end
		foreach (toks[k]) begin
			toks[k].overflow  = line_overflowed;
			toks[k].run_last  = (k == toks.size() - 1);
			toks[k].line_last = last && (k == toks.size() - 1);
			tokens_due.push_back(toks[k]);
		end
		if (last) begin
			line_pos = 0;
			in_word = 1'b0;
			quote = Q_NONE;
			word_begin = 0;
			held = P_NONE;
			held_begin = 0;
			line_overflowed = 1'b0;
		end else if (line_pos < LINE_MAX) begin
			line_pos++;
		end
	endtask

	task automatic report_mismatch(input string what, input int got, input int wanted);
		$display("%0t: mismatch in %s, got %0d, wanted %0d", $realtime, what, got, wanted);
		mismatches++;
	endtask

	// one request on the input side, with burst and gap idling
	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) :
				$urandom_range(1, 20);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		burst_left--;
		bytes_sent++;
		lex_byte(b, last);
	endtask

	task automatic send_text(input string s, input bit ends_line);
		for (int i = 0; i < s.len(); i++) begin
			send_byte(s[i], ends_line && i == s.len() - 1);
		end
	endtask

	task automatic send_seq(input logic [7:0] seq[$]);
		foreach (seq[i]) begin
			send_byte(seq[i], i == seq.size() - 1);
		end
	endtask

	function automatic logic [7:0] pick_blank();
		case ($urandom_range(0, 5))
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return CH_LF;
			3: return CH_VT;
			4: return CH_FF;
			default: return CH_CR;
		endcase
	endfunction

	function automatic logic [7:0] pick_word_byte();
		case ($urandom_range(0, 19))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'($urandom_range(8'h80, 8'hFE));
			3: return "-";
			default: return 8'("a" + $urandom_range(0, 25));
		endcase
	endfunction

	task automatic test_directed();
		// quoted blanks and operators stay in the word, then a held redirect before a word
		send_text("'a b'\"|\"<x", 1'b1);
		// append, tab, heredoc closing the line
		send_text(">>y\t<<", 1'b1);
		// zero and all-ones bytes as a word, redirect held at the line end
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(CH_GT, 1'b1);
		// line ending in whitespace
		send_text("|", 1'b0);
		send_byte(CH_VT, 1'b0);
		send_byte(CH_FF, 1'b0);
		send_byte(CH_CR, 1'b0);
		send_byte(CH_LF, 1'b1);
		// unclosed quote runs to the end
		send_text("'|", 1'b1);
	endtask

	task automatic test_backpressure();
		burst_left = 400;
		holds_asked++;
		repeat (6) send_text("a|a|a|a|a|a|a|a|a|ab", 1'b1);
	endtask

	task automatic test_long_lines();
		logic [7:0] line[$];
		string tail;
		for (int k = 0; k < 2; k++) begin
			line.delete();
			repeat (4090 + $urandom_range(0, 8)) begin
				case ($urandom_range(0, 9))
					0, 1: line.push_back(pick_blank());
					2: line.push_back(CH_PIPE);
					3: line.push_back($urandom_range(0, 1) ? CH_LT : CH_GT);
					default: line.push_back(pick_word_byte());
				endcase
			end
			// saturated word close, then an unclosed quote to the end
			tail = (k == 0) ? "a b>c|d e" : "'q r";
			for (int i = 0; i < tail.len(); i++) begin
				line.push_back(tail[i]);
			end
			send_seq(line);
		end
	endtask

	task automatic test_random_lines();
		logic [7:0] line[$];
		logic [7:0] q;
		int stop_at;
		stop_at = bytes_sent + 1500;
		while (bytes_sent < stop_at) begin
			line.delete();
			if ($urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(1, 30)) line.push_back(8'($urandom_range(0, 255)));
			end else begin
				repeat ($urandom_range(1, 8)) begin
					case ($urandom_range(0, 9))
						0: line.push_back(CH_PIPE);
						1: line.push_back(CH_LT);
						2: line.push_back(CH_GT);
						3: begin
							line.push_back(CH_LT);
							line.push_back(CH_LT);
						end
						4: begin
							line.push_back(CH_GT);
							line.push_back(CH_GT);
						end
						default: begin
							repeat ($urandom_range(1, 6)) line.push_back(pick_word_byte());
							if ($urandom_range(0, 3) == 0) begin
								q = $urandom_range(0, 1) ? CH_SQUOT : CH_DQUOT;
								line.push_back(q);
								repeat ($urandom_range(0, 5)) begin
									case ($urandom_range(0, 7))
										0: line.push_back(pick_blank());
										1: line.push_back(CH_PIPE);
										2: line.push_back(CH_LT);
										3: line.push_back(CH_GT);
										4: line.push_back((q == CH_SQUOT) ? CH_DQUOT : CH_SQUOT);
										default: line.push_back(pick_word_byte());
									endcase
								end
								if ($urandom_range(0, 9) != 0) begin
									line.push_back(q);
								end
								repeat ($urandom_range(0, 2)) line.push_back(pick_word_byte());
							end
						end
					endcase
					repeat ($urandom_range(0, 2)) line.push_back(pick_blank());
				end
			end
			send_seq(line);
		end
	endtask

	// result checking
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (tokens_due.size() == 0) begin
				report_mismatch("unexpected token", m_tdata, 0);
			end else begin
				want = tokens_due.pop_front();
				if (m_tuser[2:0] != want.kind) begin
					report_mismatch("token_kind", m_tuser[2:0], want.kind);
				end
				if (m_tdata[11:0] != want.start) begin
					report_mismatch("token_start", m_tdata[11:0], want.start);
				end
				if (m_tdata[24:12] != want.length) begin
					report_mismatch("token_length", m_tdata[24:12], want.length);
				end
				if (m_tlast != want.line_last) begin
					report_mismatch("line_last_token", m_tlast, want.line_last);
				end
				if (m_tuser[3] != want.run_last) begin
					report_mismatch("run_last", m_tuser[3], want.run_last);
				end
				if (m_tuser[4] != want.overflow) begin
					report_mismatch("line_overflow", m_tuser[4], want.overflow);
				end
			end
		end
	end

	// output side stalls, with a long hold-off on request
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (holds_begun != holds_asked) begin
			holds_begun++;
			hold_left = HOLD_CYCLES - 1;
			m_tready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				ready_mode = ready_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(16, 128);
			end
			mode_left--;
			phase++;
			case (ready_mode)
				RDY_ALWAYS: m_tready <= 1'b1;
				RDY_COIN: m_tready <= 1'($urandom_range(0, 1));
				RDY_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
				default: m_tready <= (phase[2:0] != 3'd0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_long_lines();
		test_random_lines();
		s_tvalid <= 1'b0;
		while (tokens_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0 && tokens_due.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
